@@ sv/addressable_led_serializer_core_defines.svh @@
// ============================================================================
// Assertion macros for the addressable LED serialiser core
// Shared helper macros for the concurrent checks in the RTL.
// ============================================================================
`ifndef ADDRESSABLE_LED_SERIALIZER_CORE_DEFINES_SVH
`define ADDRESSABLE_LED_SERIALIZER_CORE_DEFINES_SVH

// Property that must hold in the same cycle as its trigger.
`define ALS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Property that must hold in the cycle after its trigger.
`define ALS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/als_pkg.sv @@
// ============================================================================
// Addressable LED serialiser package
// Command codes, register map, reset values and shared types.
// ============================================================================
package als_pkg;

    // Command codes carried in the func field.
    localparam logic [1:0] FUNC_SET_ONE = 2'd0;
    localparam logic [1:0] FUNC_SET_ALL = 2'd1;
    localparam logic [1:0] FUNC_SHOW    = 2'd2;
    localparam logic [1:0] FUNC_TICK    = 2'd3;

    // Register map: register i sits at byte address 4*i.
    localparam int PADDR_W = 5;
    localparam logic [2:0] REG_HIGH0  = 3'd0;
    localparam logic [2:0] REG_HIGH1  = 3'd1;
    localparam logic [2:0] REG_PERIOD = 3'd2;
    localparam logic [2:0] REG_LATCH  = 3'd3;
    localparam logic [2:0] REG_LEDS   = 3'd4;

    // Register reset values.
    localparam logic [9:0]  RST_HIGH0  = 10'd40;
    localparam logic [9:0]  RST_HIGH1  = 10'd80;
    localparam logic [9:0]  RST_PERIOD = 10'd125;
    localparam logic [15:0] RST_LATCH  = 16'd30000;
    localparam logic [8:0]  RST_LEDS   = 9'd256;

    // Pixel format on the wire.
    localparam int BITS_PER_PIXEL = 24;
    localparam int BIT_W          = 5;

    // Depth of the queue between the front end and the line engine.
    localparam int QUEUE_DEPTH = 2;

    // Line timing settings handed to the engine.
    typedef struct packed {
        logic [9:0]  high0;
        logic [9:0]  high1;
        logic [9:0]  period;
        logic [15:0] latch;
    } t_timing;

    // A classified command word. The colour is held in wire order B, R, G.
    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  pixel_index;
        logic        in_range;
        logic [23:0] colour;
    } t_cmd;

endpackage

@@ sv/als_cmd_if.sv @@
// ============================================================================
// Command channel
// Valid/ready channel carrying one command word per handshake.
// ============================================================================
interface als_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] pixel_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, func, pixel_index, red, green, blue, input ready);
    modport sink   (input valid, func, pixel_index, red, green, blue, output ready);
endinterface

@@ sv/als_res_if.sv @@
// ============================================================================
// Result channel
// Valid/ready channel carrying one result word per handshake.
// ============================================================================
interface als_res_if;
    logic valid;
    logic ready;
    logic line_level;
    logic busy_res;
    logic frame_done;
    logic ignored;

    modport source (output valid, line_level, busy_res, frame_done, ignored, input ready);
    modport sink   (input valid, line_level, busy_res, frame_done, ignored, output ready);
endinterface

@@ sv/als_front.sv @@
// ============================================================================
// Command front end
// Takes command words, checks the pixel index and reorders the colour.
// ============================================================================
module als_front #(
    parameter int PW = 9
) (
    als_cmd_if.sink          i_cmd,
    input  logic [PW-1:0]    i_count,
    output logic             o_push_valid,
    input  logic             i_push_ready,
    output als_pkg::t_cmd    o_push_data
);

    // The word is taken whenever the queue has room.
    assign i_cmd.ready  = i_push_ready;
    assign o_push_valid = i_cmd.valid;

    // Classify the word: index check against the active pixel count, and the
    // colour rearranged into the order in which it goes out on the line.
    always_comb begin
        o_push_data.func        = i_cmd.func;
        o_push_data.pixel_index = i_cmd.pixel_index;
        o_push_data.in_range    = 32'(i_cmd.pixel_index) < 32'(i_count);
        o_push_data.colour      = {i_cmd.blue, i_cmd.red, i_cmd.green};
    end

endmodule

@@ sv/als_queue.sv @@
// ============================================================================
// Command queue
// Short first-in first-out buffer between the front end and the engine.
// ============================================================================
module als_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    output logic             o_push_ready,
    input  als_pkg::t_cmd    i_push_data,
    output logic             o_pop_valid,
    input  logic             i_pop_ready,
    output als_pkg::t_cmd    o_pop_data
);

    localparam int QPTR_W = (als_pkg::QUEUE_DEPTH > 1) ? $clog2(als_pkg::QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(als_pkg::QUEUE_DEPTH + 1);
    localparam logic [QCNT_W-1:0] FULL   = QCNT_W'(als_pkg::QUEUE_DEPTH);
    localparam logic [QPTR_W-1:0] LAST   = QPTR_W'(als_pkg::QUEUE_DEPTH - 1);

    als_pkg::t_cmd     r_slot [als_pkg::QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_count;
    logic [QPTR_W-1:0] n_wr;
    logic [QPTR_W-1:0] n_rd;
    logic [QCNT_W-1:0] n_count;
    logic              push;
    logic              pop;

    assign o_push_ready = r_count != FULL;
    assign o_pop_valid  = r_count != '0;
    assign o_pop_data   = r_slot[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointer and fill bookkeeping.
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (push) begin
            n_wr = (r_wr == LAST) ? '0 : r_wr + 1'b1;
        end
        if (pop) begin
            n_rd = (r_rd == LAST) ? '0 : r_rd + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // Storage slots carry payload only.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr] <= i_push_data;
        end
    end

endmodule

@@ sv/als_engine.sv @@
// ============================================================================
// Line engine
// Executes commands against the pixel store and drives the line waveform.
// ============================================================================
`include "addressable_led_serializer_core_defines.svh"

module als_engine #(
    parameter int MAX_LEDS = 256,
    parameter int PW       = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    output logic              o_q_ready,
    input  als_pkg::t_cmd     i_q_cmd,
    input  als_pkg::t_timing  i_tim,
    input  logic [PW-1:0]     i_count,
    als_res_if.source         o_res
);

    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
    localparam int BW = als_pkg::BIT_W;
    localparam logic [BW-1:0] LAST_BIT = BW'(als_pkg::BITS_PER_PIXEL);

    // Line phase codes.
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_SETALL = 2'd1;
    localparam logic [1:0] PH_BITS   = 2'd2;
    localparam logic [1:0] PH_LATCH  = 2'd3;

    // Pixel store with a valid bit per entry; an unwritten entry reads black.
    logic [23:0]   r_mem [MAX_LEDS];
    logic          r_valid [MAX_LEDS];
    logic [23:0]   r_rd_data;
    logic          r_rd_ok;

    logic [1:0]    r_phase;
    logic [PW-1:0] r_pix;
    logic [BW-1:0] r_bit;
    logic [23:0]   r_shift;
    logic [15:0]   r_cnt;
    logic          r_pend;
    logic [1:0]    n_phase;
    logic [PW-1:0] n_pix;
    logic [BW-1:0] n_bit;
    logic [23:0]   n_shift;
    logic [15:0]   n_cnt;
    logic          n_pend;

    logic          r_out_valid;
    logic          r_level;
    logic          r_busy;
    logic          r_done;
    logic          r_ign;

    logic          pop;
    logic          busy;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [23:0]   wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          level;
    logic          done;
    logic          ign;
    logic [PW-1:0] pix_inc;
    logic [BW-1:0] bit_inc;
    logic [15:0]   cnt_inc;
    logic [9:0]    period;
    logic [9:0]    high_sel;
    logic [9:0]    high;
    logic [23:0]   cur_word;

    // One command is executed per cycle whenever the result register is free.
    assign o_q_ready = !r_out_valid || o_res.ready;
    assign pop       = i_q_valid && o_q_ready;
    assign busy      = r_phase != PH_IDLE;

    assign pix_inc  = r_pix + 1'b1;
    assign bit_inc  = r_bit + 1'b1;
    assign cnt_inc  = r_cnt + 1'b1;
    assign period   = (i_tim.period == '0) ? 10'd1 : i_tim.period;

    // The current word comes straight from the store read just after a load.
    assign cur_word = r_pend ? (r_rd_ok ? r_rd_data : 24'd0) : r_shift;
    assign high_sel = cur_word[23] ? i_tim.high1 : i_tim.high0;
    assign high     = (high_sel > period) ? period : high_sel;

    // Command execution and line sequencing.
    always_comb begin
        n_phase = r_phase;
        n_pix   = r_pix;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_cnt   = r_cnt;
        n_pend  = r_pend;
        wr_en   = 1'b0;
        wr_addr = r_pix[AW-1:0];
        wr_data = r_shift;
        rd_en   = 1'b0;
        rd_addr = '0;
        level   = 1'b0;
        done    = 1'b0;
        ign     = 1'b0;
        if (pop) begin
            case (i_q_cmd.func)
                als_pkg::FUNC_SET_ONE: begin
                    if (busy || !i_q_cmd.in_range) begin
                        ign = 1'b1;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(i_q_cmd.pixel_index);
                        wr_data = i_q_cmd.colour;
                    end
                end
                als_pkg::FUNC_SET_ALL: begin
                    if (busy) begin
                        ign = 1'b1;
                    end else begin
                        n_shift = i_q_cmd.colour;
                        n_pix   = '0;
                        n_phase = PH_SETALL;
                    end
                end
                als_pkg::FUNC_SHOW: begin
                    if (busy) begin
                        ign = 1'b1;
                    end else begin
                        // Fetch pixel zero; it is used on the first tick.
                        n_pix   = '0;
                        n_bit   = '0;
                        n_cnt   = '0;
                        n_pend  = 1'b1;
                        rd_en   = 1'b1;
                        rd_addr = '0;
                        n_phase = PH_BITS;
                    end
                end
                default: begin
                    // A tick advances whichever phase is running.
                    case (r_phase)
                        PH_SETALL: begin
                            if (r_pix < i_count) begin
                                wr_en   = 1'b1;
                                wr_addr = r_pix[AW-1:0];
                                wr_data = r_shift;
                            end
                            n_pix = pix_inc;
                            if (pix_inc >= i_count) begin
                                n_phase = PH_IDLE;
                            end
                        end
                        PH_BITS: begin
                            level   = r_cnt < 16'(high);
                            n_pend  = 1'b0;
                            n_shift = cur_word;
                            n_cnt   = cnt_inc;
                            if (cnt_inc >= 16'(period)) begin
                                n_cnt   = '0;
                                n_shift = {cur_word[22:0], 1'b0};
                                n_bit   = bit_inc;
                                if (bit_inc >= LAST_BIT) begin
                                    n_bit = '0;
                                    n_pix = pix_inc;
                                    if (pix_inc >= i_count) begin
                                        if (i_tim.latch == '0) begin
                                            done    = 1'b1;
                                            n_phase = PH_IDLE;
                                        end else begin
                                            n_phase = PH_LATCH;
                                        end
                                    end else begin
                                        rd_en   = 1'b1;
                                        rd_addr = pix_inc[AW-1:0];
                                        n_pend  = 1'b1;
                                    end
                                end
                            end
                        end
                        PH_LATCH: begin
                            n_cnt = cnt_inc;
                            if (cnt_inc >= i_tim.latch) begin
                                n_cnt   = '0;
                                done    = 1'b1;
                                n_phase = PH_IDLE;
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_pix       <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_pix   <= n_pix;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_level <= level;
            r_busy  <= n_phase != PH_IDLE;
            r_done  <= done;
            r_ign   <= ign;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.line_level = r_level;
    assign o_res.busy_res   = r_busy;
    assign o_res.frame_done = r_done;
    assign o_res.ignored    = r_ign;

    // Valid bits: cleared by reset, set by any write to the entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_LEDS; i++) begin
                r_valid[i] <= 1'b0;
            end
        end else if (wr_en) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    // Pixel store: one write or one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_ok   <= r_valid[rd_addr];
        end
    end

    // Checks on the sequencing.
    `ALS_ASSERT_NOW(a_pend_in_bits, i_clk, i_rst_n, r_pend, r_phase == PH_BITS, "pixel load pending outside the bit phase")
    `ALS_ASSERT_NOW(a_bit_range, i_clk, i_rst_n, r_phase == PH_BITS, r_bit < LAST_BIT, "bit pointer beyond the pixel")
    `ALS_ASSERT_NOW(a_write_phase, i_clk, i_rst_n, wr_en, r_phase == PH_IDLE || r_phase == PH_SETALL, "store written while a frame runs")
    `ALS_ASSERT_NOW(a_no_rw_clash, i_clk, i_rst_n, rd_en, !wr_en, "store read and written in one cycle")
    `ALS_ASSERT_NEXT(a_pop_result, i_clk, i_rst_n, pop, r_out_valid, "executed command left no result")

endmodule

@@ sv/addressable_led_serializer_core.sv @@
// ============================================================================
// Addressable LED serialiser core
// Single-wire LED strip driver with pixel store, set and frame commands.
// ============================================================================
//
// Channel   Direction  Word carries
// i_cmd     in         func, pixel_index, red, green, blue
// o_res     out        line_level, busy_res, frame_done, ignored
// APB       in/out     timing and pixel count registers
//
// One word is executed per clock cycle while o_res is not stalled; each
// command word passes through a queue slot and then the engine's result
// register before its result word can be taken. The throughput is set by
// the line engine, which handles one word a cycle while its result register
// is free. Reset clears the pixel store through per-entry valid bits.
// A two-word queue absorbs words while o_res is stalled; once it is full the
// input stalls until a result word is taken.
//
module addressable_led_serializer_core #(
    parameter int MAX_LEDS = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    als_cmd_if.sink                      i_cmd,
    als_res_if.source                    o_res,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [als_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int PW = $clog2(MAX_LEDS + 1);

    logic [9:0]        r_high0;
    logic [9:0]        r_high1;
    logic [9:0]        r_period;
    logic [15:0]       r_latch;
    logic [8:0]        r_leds;
    logic              cfg_wr;
    logic [2:0]        reg_sel;
    logic [PW-1:0]     count;
    als_pkg::t_timing  tim;
    als_pkg::t_cmd     push_data;
    als_pkg::t_cmd     pop_data;
    logic              push_valid;
    logic              push_ready;
    logic              pop_valid;
    logic              pop_ready;

    // Register port: pready is tied high, so an access never waits.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[als_pkg::PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high0  <= als_pkg::RST_HIGH0;
            r_high1  <= als_pkg::RST_HIGH1;
            r_period <= als_pkg::RST_PERIOD;
            r_latch  <= als_pkg::RST_LATCH;
            r_leds   <= als_pkg::RST_LEDS;
        end else if (cfg_wr) begin
            case (reg_sel)
                als_pkg::REG_HIGH0:  r_high0  <= pwdata[9:0];
                als_pkg::REG_HIGH1:  r_high1  <= pwdata[9:0];
                als_pkg::REG_PERIOD: r_period <= pwdata[9:0];
                als_pkg::REG_LATCH:  r_latch  <= pwdata[15:0];
                als_pkg::REG_LEDS:   r_leds   <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        case (reg_sel)
            als_pkg::REG_HIGH0:  prdata = 32'(r_high0);
            als_pkg::REG_HIGH1:  prdata = 32'(r_high1);
            als_pkg::REG_PERIOD: prdata = 32'(r_period);
            als_pkg::REG_LATCH:  prdata = 32'(r_latch);
            als_pkg::REG_LEDS:   prdata = 32'(r_leds);
            default:             prdata = '0;
        endcase
    end

    // Active pixel count: zero acts as one, and it saturates at the store size.
    always_comb begin
        if (r_leds == '0) begin
            count = PW'(1);
        end else if (32'(r_leds) > 32'(MAX_LEDS)) begin
            count = PW'(MAX_LEDS);
        end else begin
            count = PW'(r_leds);
        end
    end

    assign tim.high0  = r_high0;
    assign tim.high1  = r_high1;
    assign tim.period = r_period;
    assign tim.latch  = r_latch;

    als_front #(
        .PW (PW)
    ) u_front (
        .i_cmd        (i_cmd),
        .i_count      (count),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_data  (push_data)
    );

    als_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    als_engine #(
        .MAX_LEDS (MAX_LEDS),
        .PW       (PW)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (pop_valid),
        .o_q_ready (pop_ready),
        .i_q_cmd   (pop_data),
        .i_tim     (tim),
        .i_count   (count),
        .o_res     (o_res)
    );

endmodule
